// File: sv/aup_pkg.sv
// Shared types and constants for the ASCII unsigned integer parser.
`timescale 1ns / 1ps

package aup_pkg;

  // Default saturation limit for the stop offset.
  localparam int unsigned MaxLenDefault = 32'd65535;
  // Default depth of the queue between the classifier and the back end.
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [5:0] RadixMax = 6'd36;
  localparam logic [5:0] HexBase  = 6'd16;
  localparam logic [5:0] DecBase  = 6'd10;
  localparam logic [5:0] AutoBase = 6'd0;
  localparam logic [5:0] NotDigit = 6'h3F;

  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerX = 8'h78;
  localparam logic [7:0] CharLowerZ = 8'h7A;

  typedef struct packed {
    logic [7:0] char_code;
    logic       string_start;
  } in_item_t;

  typedef struct packed {
    logic [31:0] parsed_value;
    logic [15:0] stop_offset;
  } out_item_t;

  // One classified character as handed from the front end to the back end.
  typedef struct packed {
    logic       start;
    logic       is_ws;
    logic       is_sign;
    logic       is_zero;
    logic       is_x;
    logic [5:0] digit;
    logic [5:0] base;
  } class_t;

  typedef enum logic [2:0] {
    PhIdle,
    PhLead,
    PhSigned,
    PhZero,
    PhDigits
  } phase_e;

endpackage

// File: sv/aup_front.sv
// Front end: radix register and per-character classification.
`timescale 1ns / 1ps

module aup_front import aup_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic [5:0] cfg_data_i,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  input  logic     full_i,
  output logic     in_stall_o,
  output logic     push_o,
  output class_t   rec_o
);

  logic [5:0] radix_q, radix_d;
  logic [7:0] c;
  logic [7:0] dig_wide;

  assign radix_d = cfg_we_i ? cfg_data_i : radix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= AutoBase;
    end else begin
      radix_q <= radix_d;
    end
  end

  assign c = in_item_i.char_code;

  always_comb begin
    dig_wide = {2'b00, NotDigit};
    if (c >= CharZero && c <= CharNine) begin
      dig_wide = c - CharZero;
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      dig_wide = c - CharLowerA + 8'(DecBase);
    end else if (c >= CharUpperA && c <= CharUpperZ) begin
      dig_wide = c - CharUpperA + 8'(DecBase);
    end
  end

  always_comb begin
    rec_o.start   = in_item_i.string_start;
    rec_o.is_ws   = (c == CharSpace) || (c >= CharTab && c <= CharCr);
    rec_o.is_sign = (c == CharPlus) || (c == CharMinus);
    rec_o.is_zero = (c == CharZero);
    rec_o.is_x    = (c == CharLowerX);
    rec_o.digit   = dig_wide[5:0];
    // Radices above the letter range behave as the largest one.
    rec_o.base    = (radix_q > RadixMax) ? RadixMax : radix_q;
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

// File: sv/aup_queue.sv
// Short queue of classified characters between front and back ends.
`timescale 1ns / 1ps

module aup_queue import aup_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  class_t push_data_i,
  input  logic   pop_i,
  output class_t pop_data_o,
  output logic   empty_o,
  output logic   full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  class_t            mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == CntW'(DEPTH));
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/aup_back.sv
// Back end: parse state machine, multiply-add accumulator and result register.
`timescale 1ns / 1ps

module aup_back import aup_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  class_t    rec_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam logic [15:0] PosCap = (MAX_LEN < 32'd65535) ? 16'(MAX_LEN) : 16'hFFFF;

  phase_e      phase_q, phase_d;
  logic [31:0] acc_q, acc_d;
  logic [5:0]  base_q, base_d;
  logic [15:0] pos_q, pos_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_item_q, out_item_d;

  phase_e      eff_phase;
  logic [31:0] eff_acc;
  logic [5:0]  eff_base;
  logic [15:0] eff_pos;
  logic [15:0] pos_inc;
  logic [5:0]  b_use;
  logic [37:0] prod;
  logic        fire;
  logic        lead_ws, lead_sign, take_zero, take_x, digit_path, digit_ok, emit;
  logic        base_hexable;

  // Fires with a queued item while the result register is free or being taken.
  assign fire  = !empty_i && (!out_valid_q || !out_stall_i);
  assign pop_o = fire;

  // A start flag restarts parsing regardless of where the last string stood.
  always_comb begin
    eff_phase = rec_i.start ? PhLead : phase_q;
    eff_acc   = rec_i.start ? '0 : acc_q;
    eff_base  = rec_i.start ? rec_i.base : base_q;
    eff_pos   = rec_i.start ? '0 : pos_q;
  end

  always_comb begin
    base_hexable = (eff_base == AutoBase) || (eff_base == HexBase);
    lead_ws      = (eff_phase == PhLead) && rec_i.is_ws;
    lead_sign    = (eff_phase == PhLead) && !rec_i.is_ws && rec_i.is_sign;
    take_zero    = (((eff_phase == PhLead) && !rec_i.is_ws && !rec_i.is_sign) ||
                    (eff_phase == PhSigned)) && base_hexable && rec_i.is_zero;
    take_x       = (eff_phase == PhZero) && rec_i.is_x;
    digit_path   = (eff_phase != PhIdle) &&
                   !(lead_ws || lead_sign || take_zero || take_x);
    b_use        = (eff_base == AutoBase) ? DecBase : eff_base;
    digit_ok     = rec_i.digit < b_use;
    emit         = fire && digit_path && !digit_ok;
    pos_inc      = (eff_pos < PosCap) ? eff_pos + 16'd1 : PosCap;
    prod         = eff_acc * b_use;
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (fire) begin
      unique case (eff_phase)
        PhIdle:  phase_d = PhIdle;
        PhLead: begin
          if (lead_ws) begin
            phase_d = PhLead;
          end else if (lead_sign) begin
            phase_d = PhSigned;
          end else if (take_zero) begin
            phase_d = PhZero;
          end else begin
            phase_d = digit_ok ? PhDigits : PhIdle;
          end
        end
        PhSigned: begin
          if (take_zero) begin
            phase_d = PhZero;
          end else begin
            phase_d = digit_ok ? PhDigits : PhIdle;
          end
        end
        PhZero: begin
          if (take_x) begin
            phase_d = PhDigits;
          end else begin
            phase_d = digit_ok ? PhDigits : PhIdle;
          end
        end
        PhDigits: phase_d = digit_ok ? PhDigits : PhIdle;
        default:  phase_d = PhIdle;
      endcase
    end
  end

  // Datapath and result register.
  always_comb begin
    acc_d       = acc_q;
    base_d      = base_q;
    pos_d       = pos_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (fire) begin
      acc_d  = eff_acc;
      base_d = eff_base;
      pos_d  = eff_pos;
      if (lead_ws || lead_sign || take_zero) begin
        pos_d = pos_inc;
      end else if (take_x) begin
        pos_d  = pos_inc;
        base_d = HexBase;
      end else if (digit_path) begin
        base_d = b_use;
        if (digit_ok) begin
          acc_d = prod[31:0] + 32'(rec_i.digit);
          pos_d = pos_inc;
        end
      end
      if (emit) begin
        out_valid_d             = 1'b1;
        out_item_d.parsed_value = eff_acc;
        out_item_d.stop_offset  = eff_pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      acc_q       <= '0;
      base_q      <= AutoBase;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      base_q      <= base_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: sv/ascii_unsigned_integer_parser.sv
// Top level of the ASCII unsigned integer parser.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o   in_item_i  (char_code, string_start)
//   out      output     out_valid_o / out_stall_i out_item_o (parsed_value, stop_offset)
//   cfg      input      cfg_we_i                  cfg_data_i (radix)
//
// One character is taken per cycle while in_stall_o is low; the back end does one
// 32-by-6 multiply-add per character, which sets the rate. The character that
// stops the number passes through the queue, and its result is then held in the
// back end's output register. Reset clears the radix to auto, empties the queue
// and returns the parser to idle. in_stall_o rises when the queue of classified
// characters is full; the back end holds while a result waits in its output
// register and out_stall_i is high.
`timescale 1ns / 1ps

module ascii_unsigned_integer_parser import aup_pkg::*; #(
  parameter int unsigned MAX_LEN     = MaxLenDefault,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o
);

  logic   push, pop, q_empty, q_full;
  class_t push_rec, pop_rec;

  aup_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .full_i     (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  aup_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_rec),
    .pop_i       (pop),
    .pop_data_o  (pop_rec),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  aup_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .rec_i       (pop_rec),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: tb/sv/tb_ascii_unsigned_integer_parser.sv
// Testbench for the ASCII unsigned integer parser: directed and random strings against a predictor.
`timescale 1ns / 1ps

module tb_ascii_unsigned_integer_parser;
  import aup_pkg::*;

  localparam int DrainCycles   = 16;
  localparam int WatchdogLimit = 2000;
  localparam int RandomItems   = 1000;
  localparam int QuietTail     = 150;
  localparam logic [15:0] OffsetCap = 16'hFFFF;
  localparam logic [7:0]  CharNul   = 8'h00;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [5:0] cfg_data_i  = '0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_item_t   in_item_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_item_o;

  // Predictor state.
  phase_e      parse_phase = PhIdle;
  logic [31:0] acc_value   = '0;
  logic [5:0]  work_base   = '0;
  logic [15:0] char_pos    = '0;
  logic [5:0]  radix_reg   = AutoBase;

  out_item_t   parse_results[$];
  out_item_t   oldest_result;
  int          fail_count  = 0;
  int          items_sent  = 0;
  int          quiet_count = 0;
  int          stall_left  = 0;
  bit          idle_on     = 1'b1;

  ascii_unsigned_integer_parser DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic is_space(input logic [7:0] c);
    return (c == CharSpace) || (c >= CharTab && c <= CharCr);
  endfunction

  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [7:0] off;
    off = 8'hFF;
    if (c >= CharZero && c <= CharNine) off = c - CharZero;
    else if (c >= CharLowerA && c <= CharLowerZ) off = c - CharLowerA + 8'd10;
    else if (c >= CharUpperA && c <= CharUpperZ) off = c - CharUpperA + 8'd10;
    return (off == 8'hFF) ? NotDigit : off[5:0];
  endfunction

  function automatic void bump_position();
    if (char_pos != OffsetCap) char_pos = char_pos + 16'd1;
  endfunction

  // Advances the parser copy by one character; returns 1 when the number stops.
  function automatic logic parse_char(input in_item_t item, output out_item_t res);
    logic [7:0] c;
    logic [5:0] d;
    c = item.char_code;
    res = '0;
    if (item.string_start) begin
      acc_value   = '0;
      char_pos    = '0;
      work_base   = (radix_reg > RadixMax) ? RadixMax : radix_reg;
      parse_phase = PhLead;
    end else if (parse_phase == PhIdle) begin
      return 1'b0;
    end

    if (parse_phase == PhLead) begin
      if (is_space(c)) begin
        bump_position();
        return 1'b0;
      end
      if (c == CharPlus || c == CharMinus) begin
        bump_position();
        parse_phase = PhSigned;
        return 1'b0;
      end
      // Anything else is handled exactly as it would be after a sign.
      parse_phase = PhSigned;
    end

    if (parse_phase == PhSigned) begin
      if ((work_base == AutoBase || work_base == HexBase) && c == CharZero) begin
        bump_position();
        parse_phase = PhZero;
        return 1'b0;
      end
      if (work_base == AutoBase) work_base = DecBase;
      parse_phase = PhDigits;
    end else if (parse_phase == PhZero) begin
      if (c == CharLowerX) begin
        bump_position();
        work_base   = HexBase;
        parse_phase = PhDigits;
        return 1'b0;
      end
      if (work_base == AutoBase) work_base = DecBase;
      parse_phase = PhDigits;
    end

    d = digit_value(c);
    if (d < work_base) begin
      acc_value = acc_value * work_base + d;
      bump_position();
      return 1'b0;
    end
    res.parsed_value = acc_value;
    res.stop_offset  = char_pos;
    parse_phase      = PhIdle;
    return 1'b1;
  endfunction

  task automatic send_char(input logic [7:0] code, input logic start);
    out_item_t res;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{char_code: code, string_start: start};
    do @(posedge clk_i); while (in_stall_o);
    if (parse_char(in_item_i, res)) parse_results.push_back(res);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
  endtask

  // Lowers valid, waits until every pending result has come out, then lets the pipe drain.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (parse_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_radix(input logic [5:0] value);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    radix_reg  = value;
  endtask

  task automatic test_auto_radix();
    set_radix(AutoBase);
    send_text(" \t-0x1fZ");
    send_text("09;");
    send_text("0x");
    send_char(CharNul, 1'b0);
  endtask

  task automatic test_radix_extremes();
    set_radix(6'd1);
    send_text("01");
    set_radix(6'd63);
    send_text("zZ!");
    set_radix(HexBase);
    send_text("0X");
    set_radix(RadixMax);
    send_text("Az.");
  endtask

  task automatic test_idle_and_restart();
    set_radix(DecBase);
    send_char("5", 1'b0);
    send_text("12");
    send_text("3");
    send_char(8'hFF, 1'b0);
    send_char("4", 1'b0);
    send_char(8'h80, 1'b1);
  endtask

  task automatic send_random_string();
    logic [7:0] chars[$];
    int eff;
    int v;
    repeat ($urandom_range(0, 3)) begin
      v = $urandom_range(8, 13);
      chars.push_back((v == 8) ? CharSpace : 8'(v));
    end
    case ($urandom_range(0, 2))
      1: chars.push_back(CharPlus);
      2: chars.push_back(CharMinus);
      default: ;
    endcase
    eff = (radix_reg > RadixMax) ? RadixMax : radix_reg;
    if ((eff == AutoBase || eff == HexBase) && $urandom_range(0, 2) == 0) begin
      chars.push_back(CharZero);
      chars.push_back(CharLowerX);
      eff = HexBase;
    end else if (eff == AutoBase) begin
      eff = DecBase;
    end
    repeat ($urandom_range(0, 12)) begin
      v = $urandom_range(0, eff - 1);
      if (v < 10) chars.push_back(CharZero + 8'(v));
      else chars.push_back(($urandom_range(0, 1) ? CharLowerA : CharUpperA) + 8'(v - 10));
    end
    case ($urandom_range(0, 3))
      0: chars.push_back(CharNul);
      1: chars.push_back(8'($urandom_range(0, 255)));
      2: chars.push_back(8'($urandom_range(128, 255)));
      default: chars.push_back(CharSpace);
    endcase
    foreach (chars[i]) send_char(chars[i], i == 0);
    items_sent += chars.size();
    // Trailing characters are normally ignored, but they continue a string that did not stop.
    repeat ($urandom_range(0, 2)) send_char(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      items_sent++;
    end
  endtask

  task automatic test_random_traffic();
    logic [5:0] radix_choices[9];
    radix_choices = '{AutoBase, 6'd1, 6'd2, 6'd8, DecBase, HexBase, RadixMax, 6'd37, 6'd63};
    items_sent = 0;
    while (items_sent < RandomItems) begin
      idle_on = (items_sent < RandomItems - QuietTail) && ($urandom_range(0, 3) != 0);
      // The closing stretch keeps the last radix so that the input never pauses.
      if (items_sent < RandomItems - QuietTail) begin
        if ($urandom_range(0, 3) == 0) set_radix(6'($urandom_range(0, 63)));
        else set_radix(radix_choices[$urandom_range(0, 8)]);
      end
      repeat ($urandom_range(8, 16)) begin
        if (items_sent >= RandomItems - QuietTail) idle_on = 1'b0;
        if ($urandom_range(0, 9) < 8) send_random_string();
        else send_noise();
      end
    end
  endtask

  // Result side: random stall bursts while idling is enabled.
  always @(posedge clk_i) begin
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 7);
    out_stall_i <= (stall_left > 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (parse_results.size() == 0) begin
        $error("unexpected result: parsed_value %0h stop_offset %0d",
               out_item_o.parsed_value, out_item_o.stop_offset);
        fail_count++;
      end else begin
        oldest_result = parse_results.pop_front();
        if (out_item_o.parsed_value !== oldest_result.parsed_value) begin
          $error("parsed_value: expected %0h, got %0h",
                 oldest_result.parsed_value, out_item_o.parsed_value);
          fail_count++;
        end
        if (out_item_o.stop_offset !== oldest_result.stop_offset) begin
          $error("stop_offset: expected %0d, got %0d",
                 oldest_result.stop_offset, out_item_o.stop_offset);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_count = 0;
    else quiet_count++;
    if (quiet_count >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_auto_radix();
    test_radix_extremes();
    test_idle_and_restart();
    test_random_traffic();
    drain_results();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
